@@ hdl/elgamal_signature_generator_unit_assert.svh @@
// Assertion macros for the signature generator.
`ifndef ELGAMAL_SIGNATURE_GENERATOR_UNIT_ASSERT_SVH
`define ELGAMAL_SIGNATURE_GENERATOR_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ hdl/esg_pkg.sv @@
// Shared types and codes of the signature generator.
package esg_pkg;
  // datapath commands
  localparam logic [3:0] CMD_NONE    = 4'd0;
  localparam logic [3:0] CMD_LOAD    = 4'd1;
  localparam logic [3:0] CMD_MM_GG   = 4'd2;  // square base
  localparam logic [3:0] CMD_MM_RG   = 4'd3;  // multiply result by base
  localparam logic [3:0] CMD_SHIFT_E = 4'd4;
  localparam logic [3:0] CMD_DIV     = 4'd5;  // start division r0/r1
  localparam logic [3:0] CMD_MM_QT   = 4'd6;
  localparam logic [3:0] CMD_EU_UPD  = 4'd7;
  localparam logic [3:0] CMD_MM_AG   = 4'd8;
  localparam logic [3:0] CMD_MM_DK   = 4'd9;
  localparam logic [3:0] CMD_PREP    = 4'd10; // take the reduced base g mod p
  localparam logic [3:0] CMD_DIFF    = 4'd11;
  localparam logic [3:0] CMD_SUB     = 4'd12; // x - a*gamma mod m

  typedef struct packed {
    logic [3:0] op;
  } esg_cmd_t;

  typedef struct packed {
    logic busy;      // multi-cycle unit working
    logic e_zero;    // exponent exhausted
    logic e_lsb;
    logic r1_zero;   // Euclid remainder zero
    logic gcd_one;
    logic p_small;   // p below two
  } esg_stat_t;
endpackage

@@ hdl/esg_datapath.sv @@
// Datapath: registers, serial modular multiplier and serial divider.
module esg_datapath #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  esg_pkg::esg_cmd_t  cmd,
  output esg_pkg::esg_stat_t stat,
  input  logic [WIDTH-1:0]   cfg_p,
  input  logic [WIDTH-1:0]   cfg_g,
  input  logic [WIDTH-1:0]   cfg_a,
  input  logic [WIDTH-1:0]   in_k,
  input  logic [WIDTH-1:0]   in_x,
  output logic [WIDTH-1:0]   gamma,
  output logic [WIDTH-1:0]   delta
);
  import esg_pkg::*;
  localparam int CW = $clog2(WIDTH + 1);
  localparam int IW = $clog2(WIDTH);

  logic [WIDTH-1:0] p, m, e, g, r, r0, r1, t0, t1, q, xm, am, dif;
  logic [WIDTH-1:0] ma, mb, mmod, macc;
  logic [CW-1:0]    cnt;
  logic [3:0]       mop;
  logic             mbusy, dbusy;
  logic [WIDTH-1:0] drem, dquo, dnum;
  // reduction unit: a mod n by restoring division, one bit per cycle
  logic [WIDTH:0]   dtrial;
  logic [WIDTH:0]   dsh;

  // modular add of x+y mod n, x,y < n
  function automatic logic [WIDTH-1:0] addm(input logic [WIDTH-1:0] x,
      input logic [WIDTH-1:0] y, input logic [WIDTH-1:0] n);
    logic [WIDTH-1:0] gap;
    gap = n - y;
    addm = (x >= gap) ? (x - gap) : (x + y);
  endfunction

  assign dsh    = {drem, dnum[WIDTH-1]};
  assign dtrial = dsh - {1'b0, r1};

  logic [WIDTH-1:0] mstep;
  assign mstep = addm(macc, macc, mmod);

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      dbusy <= 1'b0;
    end else begin
      if (mbusy) begin
        macc <= mb[cnt[IW-1:0]] ? addm(mstep, ma, mmod) : mstep;
        if (cnt == '0) begin
          mbusy <= 1'b0;
          unique case (mop)
            CMD_MM_GG: g  <= mb[0] ? addm(mstep, ma, mmod) : mstep;
            CMD_MM_RG: r  <= mb[0] ? addm(mstep, ma, mmod) : mstep;
            CMD_MM_QT: q  <= mb[0] ? addm(mstep, ma, mmod) : mstep;
            CMD_MM_AG: am <= mb[0] ? addm(mstep, ma, mmod) : mstep;
            default:   delta <= mb[0] ? addm(mstep, ma, mmod) : mstep;
          endcase
        end else begin
          cnt <= cnt - 1'b1;
        end
      end else if (dbusy) begin
        dnum <= {dnum[WIDTH-2:0], 1'b0};
        if (!dtrial[WIDTH]) begin
          drem <= dtrial[WIDTH-1:0];
          dquo <= {dquo[WIDTH-2:0], 1'b1};
        end else begin
          drem <= dsh[WIDTH-1:0];
          dquo <= {dquo[WIDTH-2:0], 1'b0};
        end
        if (cnt == '0) dbusy <= 1'b0;
        else cnt <= cnt - 1'b1;
      end
      unique case (cmd.op)
        CMD_LOAD: begin
          p <= cfg_p; m <= cfg_p - 1'b1; e <= in_k;
          // start g mod p reduction via divider
          r1 <= cfg_p; dnum <= cfg_g; drem <= '0; dquo <= '0;
          dbusy <= 1'b1; cnt <= CW'(WIDTH - 1);
          r <= (cfg_p == {{(WIDTH-1){1'b0}}, 1'b1}) ? '0 : {{(WIDTH-1){1'b0}}, 1'b1};
        end
        CMD_PREP: begin
          g <= drem;
        end
        CMD_MM_GG, CMD_MM_RG, CMD_MM_QT, CMD_MM_AG, CMD_MM_DK: begin
          mbusy <= 1'b1; mop <= cmd.op; cnt <= CW'(WIDTH - 1); macc <= '0;
          unique case (cmd.op)
            CMD_MM_GG: begin ma <= g;  mb <= g;  mmod <= p; end
            CMD_MM_RG: begin ma <= r;  mb <= g;  mmod <= p; end
            // quotient reaches m only when it must wrap to zero
            CMD_MM_QT: begin ma <= (dquo >= m) ? (dquo - m) : dquo; mb <= t1; mmod <= m; end
            CMD_MM_AG: begin ma <= am; mb <= dif; mmod <= m; end
            default:   begin ma <= dif; mb <= t0; mmod <= m; end
          endcase
        end
        CMD_SHIFT_E: e <= e >> 1;
        CMD_DIV: begin
          dnum <= r0; drem <= '0; dquo <= '0; dbusy <= 1'b1; cnt <= CW'(WIDTH - 1);
        end
        CMD_EU_UPD: begin
          // q holds q*t1 mod m here
          r0 <= r1; r1 <= drem; t0 <= t1;
          t1 <= (t0 >= q) ? (t0 - q) : (t0 + (m - q));
        end
        CMD_SUB: dif <= (xm >= q) ? (xm - q) : (xm + (m - q));
        CMD_DIFF: begin
          // sequence of reductions, driven by sub-step in e
          unique case (e[1:0])
            2'd0: begin  // gamma done: set up Euclid k mod m
              gamma <= r; r1 <= m; dnum <= in_k; drem <= '0; dquo <= '0;
              dbusy <= 1'b1; cnt <= CW'(WIDTH - 1); e <= 'd1;
            end
            2'd1: begin
              r0 <= m; r1 <= drem; t0 <= '0;
              t1 <= (m == {{(WIDTH-1){1'b0}}, 1'b1}) ? '0 : {{(WIDTH-1){1'b0}}, 1'b1};
              e <= 'd2;
            end
            2'd2: begin  // x mod m
              r1 <= m; dnum <= in_x; drem <= '0; dquo <= '0;
              dbusy <= 1'b1; cnt <= CW'(WIDTH - 1); e <= 'd3; dif <= '0;
            end
            default: begin
              unique case (dif[1:0])
                2'd0: begin xm <= drem; dnum <= cfg_a; drem <= '0; dquo <= '0;
                  dbusy <= 1'b1; cnt <= CW'(WIDTH - 1); dif <= 'd1; end
                2'd1: begin am <= drem; dnum <= gamma; drem <= '0; dquo <= '0;
                  dbusy <= 1'b1; cnt <= CW'(WIDTH - 1); dif <= 'd2; end
                2'd2: begin dif <= drem; dquo <= '0; end
                default: ;
              endcase
            end
          endcase
        end
        default: ;
      endcase
      if (cmd.op == CMD_MM_AG) q <= '0;
      if (mbusy && cnt == '0 && mop == CMD_MM_AG) q <= mb[0] ? addm(mstep, ma, mmod) : mstep;
    end
  end

  assign stat.busy    = mbusy | dbusy;
  assign stat.e_zero  = (e == '0);
  assign stat.e_lsb   = e[0];
  assign stat.r1_zero = (r1 == '0);
  assign stat.gcd_one = (r0 == {{(WIDTH-1){1'b0}}, 1'b1});
  assign stat.p_small = (p < {{(WIDTH-2){1'b0}}, 2'd2});
endmodule

@@ hdl/esg_controller.sv @@
// Sequencer that steps the datapath through exponentiation and Euclid.
module esg_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  esg_pkg::esg_stat_t stat,
  output esg_pkg::esg_cmd_t  cmd,
  output logic               busy,
  output logic               done,
  output logic               fail
);
  import esg_pkg::*;
  localparam logic [4:0] S_IDLE = 5'd0,  S_RED = 5'd1,  S_EXP = 5'd2,
                         S_MRG = 5'd3,  S_MGG = 5'd4,  S_KM = 5'd5,
                         S_KMW = 5'd6,  S_EU = 5'd7,  S_EUD = 5'd8,
                         S_EUM = 5'd9,  S_EUU = 5'd10, S_X = 5'd11,
                         S_XW = 5'd12, S_A = 5'd13,  S_AW = 5'd14,
                         S_G = 5'd15,  S_GW = 5'd16, S_GS = 5'd17,
                         S_AG = 5'd18, S_SUB = 5'd19, S_DK = 5'd20,
                         S_FIN = 5'd21, S_INIT = 5'd22, S_GW2 = 5'd23;
  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.op = CMD_NONE;
    done = 1'b0;
    fail = 1'b0;
    unique case (state)
      S_IDLE: if (start) begin cmd.op = CMD_LOAD; state_next = S_RED; end
      S_RED: if (!stat.busy) begin
        if (stat.p_small) begin done = 1'b1; fail = 1'b1; state_next = S_IDLE; end
        else begin cmd.op = CMD_PREP; state_next = S_EXP; end
      end
      S_EXP: if (!stat.busy) begin
        if (stat.e_zero) state_next = S_INIT;
        else if (stat.e_lsb) begin cmd.op = CMD_MM_RG; state_next = S_MRG; end
        else begin cmd.op = CMD_MM_GG; state_next = S_MGG; end
      end
      S_MRG: if (!stat.busy) begin cmd.op = CMD_MM_GG; state_next = S_MGG; end
      S_MGG: if (!stat.busy) begin cmd.op = CMD_SHIFT_E; state_next = S_EXP; end
      S_INIT: begin cmd.op = CMD_DIFF; state_next = S_KM; end      // e<-1, k mod m
      S_KM: if (!stat.busy) begin cmd.op = CMD_DIFF; state_next = S_EU; end
      S_EU: if (!stat.busy) begin
        if (stat.r1_zero) state_next = S_X;
        else begin cmd.op = CMD_DIV; state_next = S_EUD; end
      end
      S_EUD: if (!stat.busy) begin cmd.op = CMD_MM_QT; state_next = S_EUM; end
      S_EUM: if (!stat.busy) begin cmd.op = CMD_EU_UPD; state_next = S_EU; end
      S_X: begin
        if (!stat.gcd_one) begin done = 1'b1; fail = 1'b1; state_next = S_IDLE; end
        else begin cmd.op = CMD_DIFF; state_next = S_XW; end
      end
      S_XW: if (!stat.busy) begin cmd.op = CMD_DIFF; state_next = S_AW; end
      S_AW: if (!stat.busy) begin cmd.op = CMD_DIFF; state_next = S_GW; end
      S_GW: if (!stat.busy) begin cmd.op = CMD_DIFF; state_next = S_AG; end
      S_AG: begin cmd.op = CMD_MM_AG; state_next = S_SUB; end
      S_SUB: if (!stat.busy) begin cmd.op = CMD_SUB; state_next = S_DK; end
      S_DK: begin cmd.op = CMD_MM_DK; state_next = S_FIN; end
      S_FIN: if (!stat.busy) begin done = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end
  assign busy = (state != S_IDLE);
endmodule

@@ hdl/elgamal_signature_generator_unit.sv @@
// Top level of the ElGamal signature generator.
//  channel | dir | payload
//  s_axis  | in  | tdata {message, nonce}
//  m_axis  | out | tdata {delta, gamma}, tuser status
//  apb     | cfg | p @0, alpha @4, a @8
// One word at a time. Exponent: a square per nonce bit and a multiply per set
// bit. Euclid: a division and a product per round; five reductions and two
// products come on top. Reset restores p=5, alpha=2, a=1. The output register
// holds the result under stall; a new word is taken once the result has left.
module elgamal_signature_generator_unit #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [63:0]      s_axis_tdata,   // nonce, message
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // gamma, delta
  output logic             m_axis_tuser,   // status
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import esg_pkg::*;
  localparam logic [3:0] ADDR_P = 4'h0, ADDR_G = 4'h4, ADDR_A = 4'h8;

  logic [WIDTH-1:0] reg_p, reg_g, reg_a, k, x, k_in, gamma, delta;
  esg_cmd_t  cmd;
  esg_stat_t stat;
  logic start, busy, done, fail;

  assign pready = 1'b1;
  // hold registers, masked to the datapath width
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_p <= WIDTH'(5); reg_g <= WIDTH'(2); reg_a <= WIDTH'(1);
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        ADDR_P:  reg_p <= WIDTH'(pwdata);
        ADDR_G:  reg_g <= WIDTH'(pwdata);
        ADDR_A:  reg_a <= WIDTH'(pwdata);
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr)
      ADDR_P:  prdata = 32'(reg_p);
      ADDR_G:  prdata = 32'(reg_g);
      ADDR_A:  prdata = 32'(reg_a);
      default: prdata = '0;
    endcase
  end

  assign s_axis_tready = !busy && !m_axis_tvalid;
  assign start = s_axis_tvalid && s_axis_tready;
  always_ff @(posedge clk) begin
    if (start) begin
      k <= WIDTH'(s_axis_tdata[31:0]);
      x <= WIDTH'(s_axis_tdata[63:32]);
    end
  end
  // the load command reads the nonce straight off the bus at the accepting edge
  assign k_in = start ? WIDTH'(s_axis_tdata[31:0]) : k;

  esg_controller u_ctrl (.clk, .rst, .start, .stat, .cmd, .busy, .done, .fail);
  esg_datapath #(.WIDTH(WIDTH)) u_dp (.clk, .rst, .cmd, .stat, .cfg_p(reg_p),
    .cfg_g(reg_g), .cfg_a(reg_a), .in_k(k_in), .in_x(x), .gamma, .delta);

  // drop the delta on failure; gamma is zero when p is degenerate
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (done) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    if (done) begin
      m_axis_tuser <= fail && !(stat.p_small == 1'b0 && stat.gcd_one);
      m_axis_tdata[31:0]  <= stat.p_small ? 32'd0 : 32'(gamma);
      m_axis_tdata[63:32] <= fail ? 32'd0 : 32'(delta);
    end
  end
endmodule

@@ hdl/esg_checker.sv @@
// Port-level checker for the signature generator, bound to the top level.
`include "elgamal_signature_generator_unit_assert.svh"
module esg_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic pready
);
  `ASSERT_IMPL(no_take_while_full, clk, rst, m_axis_tvalid, !s_axis_tready)
  `ASSERT_NEXT(busy_after_take, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `ASSERT_IMPL(apb_ready, clk, rst, 1'b1, pready)
endmodule
bind elgamal_signature_generator_unit esg_checker u_chk (.*);

@@ dv/testbench.sv @@
// Self-checking testbench for the ElGamal signature generator unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDTH = 32;
  localparam logic [3:0] REG_PRIME = 4'd0;
  localparam logic [3:0] REG_ALPHA = 4'd4;
  localparam logic [3:0] REG_KEY   = 4'd8;
  localparam logic [3:0] REG_HOLE  = 4'd12;  // unmapped, writes dropped
  // worst case word: exponent walk plus Euclid rounds, padded
  localparam int WORD_CYCLES = 32 * (2 * WIDTH + 4) + 48 * 3 * WIDTH + 200;

  typedef struct packed {
    logic [31:0] gamma;
    logic [31:0] delta;
    logic        status;
  } signature_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // nonce [31:0], message [63:32]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // gamma [31:0], delta [63:32]
  logic m_axis_tuser;               // status
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // local copy of the signing parameters
  logic [31:0] prime_p = 32'd5, alpha_g = 32'd2, key_a = 32'd1;
  signature_t sig_queue[$];
  int failures = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_off_cycles = 0;

  elgamal_signature_generator_unit #(.WIDTH(WIDTH)) DUT (.*);

  always #10 clk = ~clk;

  function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [127:0] prod;
    prod = x * y;
    return 64'(prod % m);
  endfunction

  function automatic logic [63:0] pow_mod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] r;
    r = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) r = mul_mod(r, b, m);
      b = mul_mod(b, b, m);
      e = e >> 1;
    end
    return r;
  endfunction

  // signature for one nonce/message pair under the current parameters
  function automatic signature_t sign_word(logic [31:0] k, logic [31:0] x);
    signature_t s;
    logic [63:0] m, r0, r1, t0, t1, q, nr, nt, qt, ag, xm, diff;
    s = '{gamma: 32'd0, delta: 32'd0, status: 1'b1};
    if (prime_p >= 2) begin
      m = prime_p - 1;
      s.gamma = 32'(pow_mod(alpha_g, k, prime_p));
      r0 = m; r1 = k % m; t0 = 0; t1 = 1 % m;
      while (r1 != 0) begin
        q = r0 / r1;
        nr = r0 - q * r1;
        qt = mul_mod(q % m, t1, m);
        nt = (t0 >= qt) ? t0 - qt : t0 + (m - qt);
        r0 = r1; r1 = nr; t0 = t1; t1 = nt;
      end
      if (r0 == 1) begin
        xm = x % m;
        ag = mul_mod(key_a % m, s.gamma % m, m);
        diff = (xm >= ag) ? xm - ag : xm + (m - ag);
        s.delta = 32'(mul_mod(diff, t0, m));
        s.status = 1'b0;
      end
    end
    return s;
  endfunction

  // receiver: random stall, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // check each result word against the oldest pending signature
  always @(posedge clk) begin
    signature_t exp_sig;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (sig_queue.size() == 0) begin
        $error("unexpected result word gamma=%0d", m_axis_tdata[31:0]);
        failures++;
      end else begin
        exp_sig = sig_queue.pop_front();
        if (m_axis_tdata[31:0] !== exp_sig.gamma) begin
          $error("gamma expected %0d actual %0d", exp_sig.gamma, m_axis_tdata[31:0]);
          failures++;
        end
        if (m_axis_tdata[63:32] !== exp_sig.delta) begin
          $error("delta expected %0d actual %0d", exp_sig.delta, m_axis_tdata[63:32]);
          failures++;
        end
        if (m_axis_tuser !== exp_sig.status) begin
          $error("status expected %0d actual %0d", exp_sig.status, m_axis_tuser);
          failures++;
        end
      end
    end
  end

  // drain pending results, then let the datapath settle
  task automatic wait_drained();
    while (sig_queue.size() != 0) @(posedge clk);
    repeat (WORD_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access; mirror mapped registers
  task automatic write_reg(logic [3:0] addr, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (addr)
      REG_PRIME: prime_p = value;
      REG_ALPHA: alpha_g = value;
      REG_KEY:   key_a = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_params(logic [31:0] p, logic [31:0] g, logic [31:0] a);
    wait_drained();
    write_reg(REG_PRIME, p);
    write_reg(REG_ALPHA, g);
    write_reg(REG_KEY, a);
  endtask

  // offer one word, record its signature on acceptance
  task automatic send_word(logic [31:0] k, logic [31:0] x);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {x, k};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sig_queue.push_back(sign_word(k, x));
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_word(32'd3, 32'd4);
    send_word(32'd2, 32'd1);   // not invertible mod 4
    send_word(32'd0, 32'd0);   // zero nonce
  endtask

  task automatic test_directed();
    set_params(32'd467, 32'd2, 32'd127);
    send_word(32'd213, 32'd100);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'd1, 32'd0);
    send_word(32'd466, 32'd466);
    wait_drained();
    write_reg(REG_HOLE, 32'hDEAD_BEEF);  // ignored write
    send_word(32'd5, 32'd7);
    set_params(32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'd7, 32'hAAAA_5555);
    set_params(32'd2, 32'd3, 32'd1);     // modulus two
    send_word(32'd9, 32'd9);
    set_params(32'd1, 32'd2, 32'd1);     // degenerate modulus
    send_word(32'd3, 32'd3);
    set_params(32'd0, 32'd0, 32'd0);
    send_word(32'd3, 32'd3);
  endtask

  task automatic test_random(int count);
    logic [31:0] k;
    for (int i = 0; i < count; i++) begin
      if (i % 12 == 0)
        set_params($urandom_range(7) == 0 ? $urandom() : $urandom_range(4, 1000) | 1,
                   $urandom(), $urandom());
      k = $urandom();
      if ($urandom_range(3) == 0) k = k & 32'h0000_FFFF;
      else k[0] = 1'b1;  // odd nonces are more often invertible
      send_word(k, $urandom());
    end
  endtask

  // long receiver stall while the sender keeps offering words
  task automatic test_back_pressure();
    wait_drained();
    hold_off_cycles = 3 * WORD_CYCLES;
    repeat (4) send_word($urandom() | 1, $urandom());
    wait_drained();  // sender pauses until everything is back
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    send_idle_pct = 6; recv_idle_pct = 64;
    test_random(50);
    send_idle_pct = 64; recv_idle_pct = 6;
    test_random(50);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_back_pressure();
    test_random(40);
    wait_drained();
    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // watchdog
  initial begin
    #(64'd200 * WORD_CYCLES * 20 * 3);
    $display("Test completed with failures");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/esg_pkg.sv
hdl/esg_datapath.sv
hdl/esg_controller.sv
hdl/elgamal_signature_generator_unit.sv
hdl/esg_checker.sv
dv/testbench.sv
